// ===== hdl/bhv_pkg.sv =====
`default_nettype none

package bhv_pkg;

   localparam int unsigned ByteWidth   = 8;
   localparam int unsigned PosWidth    = 6;
   localparam int unsigned StatusWidth = 4;
   localparam int unsigned DimWidth    = 31;
   localparam int unsigned BppWidth    = 16;
   localparam int unsigned WordWidth   = 32;
   localparam int unsigned RspDataWidth = 176;

   localparam logic [PosWidth-1:0] PosMagic   = 6'd1;
   localparam logic [PosWidth-1:0] PosSize    = 6'd5;
   localparam logic [PosWidth-1:0] PosOffset  = 6'd13;
   localparam logic [PosWidth-1:0] PosInfo    = 6'd17;
   localparam logic [PosWidth-1:0] PosWidthF  = 6'd21;
   localparam logic [PosWidth-1:0] PosHeight  = 6'd25;
   localparam logic [PosWidth-1:0] PosPlanes  = 6'd27;
   localparam logic [PosWidth-1:0] PosBpp     = 6'd29;
   localparam logic [PosWidth-1:0] PosComp    = 6'd33;
   localparam logic [PosWidth-1:0] PosHres    = 6'd41;
   localparam logic [PosWidth-1:0] PosVres    = 6'd45;
   localparam logic [PosWidth-1:0] PosColors  = 6'd49;
   localparam logic [PosWidth-1:0] PosLast    = 6'd53;

   localparam logic [15:0]          MagicWord = 16'h4D42;
   localparam logic [WordWidth-1:0] InfoSize  = 32'd40;
   localparam logic [15:0]          PlanesOne = 16'd1;

   localparam logic [StatusWidth-1:0] StOk     = 4'd0;
   localparam logic [StatusWidth-1:0] StTrunc  = 4'd1;
   localparam logic [StatusWidth-1:0] StMagic  = 4'd2;
   localparam logic [StatusWidth-1:0] StInfo   = 4'd3;
   localparam logic [StatusWidth-1:0] StWidth  = 4'd4;
   localparam logic [StatusWidth-1:0] StHeight = 4'd5;
   localparam logic [StatusWidth-1:0] StPlanes = 4'd6;
   localparam logic [StatusWidth-1:0] StComp   = 4'd7;
   localparam logic [StatusWidth-1:0] StHres   = 4'd8;
   localparam logic [StatusWidth-1:0] StVres   = 4'd9;

   typedef struct packed {
      logic [ByteWidth-1:0] data_byte;
      logic                 file_end;
   } item_type;

   typedef struct packed {
      logic [StatusWidth-1:0] status;
      logic [WordWidth-1:0]   colors_used;
      logic [WordWidth-1:0]   file_size;
      logic [WordWidth-1:0]   pixel_offset;
      logic [BppWidth-1:0]    bits_per_pixel;
      logic [DimWidth-1:0]    image_height;
      logic [DimWidth-1:0]    image_width;
   } result_type;

   typedef struct packed {
      logic fire;
   } stage_ctrl_type;

   function automatic logic positive32(input logic [WordWidth-1:0] v);
      return (v != '0) && !v[WordWidth-1];
   endfunction

endpackage

`default_nettype wire

// ===== hdl/bmp_header_validator.sv =====
// Channel   Direction  tdata                                     tuser / tlast
// req_      in         [7:0] data_byte                           tlast = file_end
// rsp_      out        width, height, bpp, offset, size, colors  tuser[3:0] = status
//
// Each byte is registered on input, checked from the input register and its
// result, if any, lands in the output register, which drives rsp_tvalid; one
// byte per cycle is sustained while the rsp_ side does not stall.
// Reset clears the parser state and both valid flags.
// A stalled rsp_ side holds the result; the input side keeps taking bytes
// until the input register is also full, then req_tready drops.
`default_nettype none

module bmp_header_validator (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   input  wire logic [bhv_pkg::ByteWidth-1:0]       req_tdata,  // [7:0] data_byte
   input  wire logic                                req_tlast,
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   // [30:0] image_width, [61:31] image_height, [77:62] bits_per_pixel,
   // [109:78] pixel_offset, [141:110] file_size, [173:142] colors_used
   output logic [bhv_pkg::RspDataWidth-1:0]         rsp_tdata,
   output logic [bhv_pkg::StatusWidth-1:0]          rsp_tuser   // [3:0] status
);
   import bhv_pkg::*;

   item_type       req_item;
   item_type       item;
   stage_ctrl_type ctrl;
   logic           take;
   logic           emit;
   result_type     result;
   result_type     rsp_result;

   assign req_item.data_byte = req_tdata;
   assign req_item.file_end  = req_tlast;

   bhv_input_stage u_input (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_item   (req_item),
      .take       (take),
      .ctrl       (ctrl),
      .item       (item)
   );

   bhv_parser u_parser (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (ctrl),
      .item   (item),
      .emit   (emit),
      .result (result)
   );

   bhv_output_stage u_output (
      .clock      (clock),
      .reset      (reset),
      .emit       (emit),
      .result     (result),
      .take       (take),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_result (rsp_result)
   );

   assign rsp_tdata = {2'b00,
                       rsp_result.colors_used,
                       rsp_result.file_size,
                       rsp_result.pixel_offset,
                       rsp_result.bits_per_pixel,
                       rsp_result.image_height,
                       rsp_result.image_width};
   assign rsp_tuser = rsp_result.status;

endmodule

`default_nettype wire

// ===== hdl/bhv_input_stage.sv =====
`default_nettype none

module bhv_input_stage (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_tvalid,
   output logic                   req_tready,
   input  wire bhv_pkg::item_type req_item,
   input  wire logic              take,
   output bhv_pkg::stage_ctrl_type ctrl,
   output bhv_pkg::item_type      item
);
   import bhv_pkg::*;

   logic     valid_ff;
   logic     valid_in;
   item_type item_ff;

   assign req_tready = !valid_ff || take;
   assign valid_in   = (req_tvalid && req_tready) || (valid_ff && !take);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         item_ff <= req_item;
      end
   end

   assign ctrl.fire  = valid_ff && take;
   assign item       = item_ff;

endmodule

`default_nettype wire

// ===== hdl/bhv_parser.sv =====
`default_nettype none

module bhv_parser (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire bhv_pkg::stage_ctrl_type ctrl,
   input  wire bhv_pkg::item_type      item,
   output logic                        emit,
   output bhv_pkg::result_type         result
);
   import bhv_pkg::*;

   logic [PosWidth-1:0]  pos_ff, pos_in;
   logic                 finished_ff, finished_in;
   logic [WordWidth-1:0] shift_ff, shift_in;
   logic [DimWidth-1:0]  width_ff, width_in;
   logic [DimWidth-1:0]  height_ff, height_in;
   logic [BppWidth-1:0]  bpp_ff, bpp_in;
   logic [WordWidth-1:0] offset_ff, offset_in;
   logic [WordWidth-1:0] size_ff, size_in;
   logic [WordWidth-1:0] colors_ff, colors_in;

   logic [WordWidth-1:0]   shift_new;
   logic [15:0]            half;
   logic [StatusWidth-1:0] check_status;
   logic [StatusWidth-1:0] emit_status;
   logic                   ok;

   assign shift_new = {item.data_byte, shift_ff[WordWidth-1:ByteWidth]};
   assign half      = shift_new[WordWidth-1:16];

   always_comb begin
      check_status = StOk;
      unique case (pos_ff)
         PosMagic:  if (half != MagicWord) check_status = StMagic;
         PosInfo:   if (shift_new != InfoSize) check_status = StInfo;
         PosWidthF: if (!positive32(shift_new)) check_status = StWidth;
         PosHeight: if (!positive32(shift_new)) check_status = StHeight;
         PosPlanes: if (half != PlanesOne) check_status = StPlanes;
         PosComp:   if (shift_new != '0) check_status = StComp;
         PosHres:   if (!positive32(shift_new)) check_status = StHres;
         PosVres:   if (!positive32(shift_new)) check_status = StVres;
         default:   check_status = StOk;
      endcase
   end

   always_comb begin
      emit_status = check_status;
      if (check_status == StOk && pos_ff < PosLast && item.file_end) begin
         emit_status = StTrunc;
      end
   end

   assign emit = ctrl.fire && !finished_ff
                 && (check_status != StOk || pos_ff >= PosLast || item.file_end);

   always_comb begin
      pos_in      = pos_ff;
      finished_in = finished_ff;
      shift_in    = shift_ff;
      width_in    = width_ff;
      height_in   = height_ff;
      bpp_in      = bpp_ff;
      offset_in   = offset_ff;
      size_in     = size_ff;
      colors_in   = colors_ff;
      if (ctrl.fire) begin
         if (item.file_end) begin
            pos_in      = '0;
            finished_in = 1'b0;
            shift_in    = '0;
            width_in    = '0;
            height_in   = '0;
            bpp_in      = '0;
            offset_in   = '0;
            size_in     = '0;
            colors_in   = '0;
         end else if (!finished_ff) begin
            shift_in = shift_new;
            unique case (pos_ff)
               PosSize:   size_in = shift_new;
               PosOffset: offset_in = shift_new;
               PosWidthF: width_in = shift_new[DimWidth-1:0];
               PosHeight: height_in = shift_new[DimWidth-1:0];
               PosBpp:    bpp_in = half;
               PosColors: colors_in = shift_new;
               default:   ;
            endcase
            if (emit) begin
               finished_in = 1'b1;
            end else begin
               pos_in = pos_ff + PosWidth'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff      <= '0;
         finished_ff <= 1'b0;
         shift_ff    <= '0;
         width_ff    <= '0;
         height_ff   <= '0;
         bpp_ff      <= '0;
         offset_ff   <= '0;
         size_ff     <= '0;
         colors_ff   <= '0;
      end else begin
         pos_ff      <= pos_in;
         finished_ff <= finished_in;
         shift_ff    <= shift_in;
         width_ff    <= width_in;
         height_ff   <= height_in;
         bpp_ff      <= bpp_in;
         offset_ff   <= offset_in;
         size_ff     <= size_in;
         colors_ff   <= colors_in;
      end
   end

   // The ok result comes only at the final header byte, which captures nothing.
   assign ok = (emit_status == StOk);

   always_comb begin
      result.status         = emit_status;
      result.image_width    = ok ? width_ff  : '0;
      result.image_height   = ok ? height_ff : '0;
      result.bits_per_pixel = ok ? bpp_ff    : '0;
      result.pixel_offset   = ok ? offset_ff : '0;
      result.file_size      = ok ? size_ff   : '0;
      result.colors_used    = ok ? colors_ff : '0;
   end

endmodule

`default_nettype wire

// ===== hdl/bhv_output_stage.sv =====
`default_nettype none

module bhv_output_stage (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                emit,
   input  wire bhv_pkg::result_type result,
   output logic                     take,
   output logic                     rsp_tvalid,
   input  wire logic                rsp_tready,
   output bhv_pkg::result_type      rsp_result
);
   import bhv_pkg::*;

   logic       valid_ff;
   logic       valid_in;
   result_type result_ff;

   assign take     = !valid_ff || rsp_tready;
   assign valid_in = emit || (valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         result_ff <= result;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_result = result_ff;

endmodule

`default_nettype wire

// ===== hdl/bhv_checker.sv =====
`default_nettype none

module bhv_checker (
   input wire logic                              clock,
   input wire logic                              reset,
   input wire logic                              rsp_tvalid,
   input wire logic                              rsp_tready,
   input wire logic [bhv_pkg::RspDataWidth-1:0]  rsp_tdata,
   input wire logic [bhv_pkg::StatusWidth-1:0]   rsp_tuser
);
   import bhv_pkg::*;

   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("Result valid right after reset.");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("Stalled result changed.");

   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tuser <= StVres)
      else $error("Status code out of range.");

   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != StOk |-> rsp_tdata == '0)
      else $error("Failed header carries nonzero fields.");

   a_ok_dims: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == StOk |-> rsp_tdata[30:0] != '0 && rsp_tdata[61:31] != '0)
      else $error("Accepted header has a zero dimension.");

endmodule

bind bmp_header_validator bhv_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire

// ===== test/bmp_header_validator_tb.sv =====
`default_nettype none

module bmp_header_validator_tb;
   import bhv_pkg::*;

   localparam int unsigned WatchdogLimit = 3000;
   localparam int unsigned HeaderBytes   = PosLast + 1;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [ByteWidth-1:0]    req_tdata  = '0;
   logic                    req_tlast  = 1'b0;
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [RspDataWidth-1:0] rsp_tdata;
   logic [StatusWidth-1:0]  rsp_tuser;

   bmp_header_validator uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #6 clock = ~clock;

   // Header parser state as seen from the byte stream.
   logic [PosWidth-1:0]  hdr_pos    = '0;
   logic                 hdr_done   = 1'b0;
   logic [WordWidth-1:0] hdr_shift  = '0;
   logic [DimWidth-1:0]  cap_width  = '0;
   logic [DimWidth-1:0]  cap_height = '0;
   logic [BppWidth-1:0]  cap_bpp    = '0;
   logic [WordWidth-1:0] cap_offset = '0;
   logic [WordWidth-1:0] cap_size   = '0;
   logic [WordWidth-1:0] cap_colors = '0;

   result_type hdr_verdicts[$];

   logic [ByteWidth-1:0] hdr_img [0:HeaderBytes-1];

   int          fail_count   = 0;
   int          bytes_sent   = 0;
   int          files_sent   = 0;
   int          rsp_hold     = 0;
   logic        idling_on    = 1'b1;
   int unsigned stall_cycles = 0;

   task automatic clear_parser();
      hdr_pos    = '0;
      hdr_done   = 1'b0;
      hdr_shift  = '0;
      cap_width  = '0;
      cap_height = '0;
      cap_bpp    = '0;
      cap_offset = '0;
      cap_size   = '0;
      cap_colors = '0;
   endtask

   task automatic parse_byte(input logic [ByteWidth-1:0] b, input logic last);
      logic [StatusWidth-1:0] st;
      logic                   emit;
      result_type             verdict;
      st   = StOk;
      emit = 1'b0;
      if (!hdr_done) begin
         hdr_shift = {b, hdr_shift[WordWidth-1:ByteWidth]};
         case (hdr_pos)
            PosMagic: begin
               if (hdr_shift[31:16] != MagicWord) st = StMagic;
            end
            PosSize: cap_size = hdr_shift;
            PosOffset: cap_offset = hdr_shift;
            PosInfo: begin
               if (hdr_shift != InfoSize) st = StInfo;
            end
            PosWidthF: begin
               if ($signed(hdr_shift) < 1) st = StWidth;
               else cap_width = hdr_shift[DimWidth-1:0];
            end
            PosHeight: begin
               if ($signed(hdr_shift) < 1) st = StHeight;
               else cap_height = hdr_shift[DimWidth-1:0];
            end
            PosPlanes: begin
               if (hdr_shift[31:16] != PlanesOne) st = StPlanes;
            end
            PosBpp: cap_bpp = hdr_shift[31:16];
            PosComp: begin
               if (hdr_shift != '0) st = StComp;
            end
            PosHres: begin
               if ($signed(hdr_shift) < 1) st = StHres;
            end
            PosVres: begin
               if ($signed(hdr_shift) < 1) st = StVres;
            end
            PosColors: cap_colors = hdr_shift;
            default: ;
         endcase
         if (st != StOk || hdr_pos >= PosLast) begin
            emit = 1'b1;
         end else if (last) begin
            st   = StTrunc;
            emit = 1'b1;
         end
         if (emit) begin
            verdict = '0;
            verdict.status = st;
            if (st == StOk) begin
               verdict.image_width    = cap_width;
               verdict.image_height   = cap_height;
               verdict.bits_per_pixel = cap_bpp;
               verdict.pixel_offset   = cap_offset;
               verdict.file_size      = cap_size;
               verdict.colors_used    = cap_colors;
            end
            hdr_verdicts = {hdr_verdicts, verdict};
            hdr_done = 1'b1;
         end else begin
            hdr_pos = hdr_pos + PosWidth'(1);
         end
      end
      if (last) clear_parser();
   endtask

   task automatic send_byte(input logic [ByteWidth-1:0] b, input logic last);
      while (idling_on && $urandom_range(99) < 14) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      parse_byte(b, last);
      bytes_sent++;
   endtask

   // Sends the first hdr_count bytes of the header image, then extra random
   // bytes; the final byte of the whole stream marks the end of the file.
   task automatic send_stream(input int hdr_count, input int extra);
      int total;
      total = hdr_count + extra;
      for (int i = 0; i < total; i++) begin
         send_byte(i < hdr_count ? hdr_img[i] : ByteWidth'($urandom), i == total - 1);
      end
      files_sent++;
   endtask

   function automatic void put_le(input int at, input int n, input logic [WordWidth-1:0] v);
      for (int i = 0; i < n; i++) hdr_img[at+i] = v[8*i +: 8];
   endfunction

   function automatic logic [WordWidth-1:0] pick_word();
      case ($urandom_range(5))
         0: return '0;
         1: return '1;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [WordWidth-1:0] pick_positive();
      logic [WordWidth-1:0] w;
      case ($urandom_range(5))
         0: w = 32'd1;
         1: w = 32'h7FFF_FFFF;
         default: w = $urandom & 32'h7FFF_FFFF;
      endcase
      if (w == '0) w = 32'd1;
      return w;
   endfunction

   function automatic logic [WordWidth-1:0] pick_nonpositive();
      if ($urandom_range(2) == 0) return '0;
      return $urandom | 32'h8000_0000;
   endfunction

   function automatic logic [WordWidth-1:0] pick_nonzero();
      logic [WordWidth-1:0] w;
      w = ($urandom_range(1) == 0) ? (32'd1 << $urandom_range(31)) : $urandom;
      if (w == '0) w = 32'd1;
      return w;
   endfunction

   function automatic void make_header();
      put_le(0, 2, MagicWord);
      put_le(PosSize - 3, 4, pick_word());
      put_le(PosSize + 1, 4, pick_word());
      put_le(PosOffset - 3, 4, pick_word());
      put_le(PosInfo - 3, 4, InfoSize);
      put_le(PosWidthF - 3, 4, pick_positive());
      put_le(PosHeight - 3, 4, pick_positive());
      put_le(PosPlanes - 1, 2, PlanesOne);
      put_le(PosBpp - 1, 2, pick_word());
      put_le(PosComp - 3, 4, '0);
      put_le(PosComp + 1, 4, pick_word());
      put_le(PosHres - 3, 4, pick_positive());
      put_le(PosVres - 3, 4, pick_positive());
      put_le(PosColors - 3, 4, pick_word());
      put_le(PosColors + 1, 4, pick_word());
   endfunction

   // Corrupts one checked field and returns the position of its last byte.
   function automatic int break_field(input int which);
      case (which)
         0: begin
            put_le(0, 2, MagicWord ^ 16'($urandom_range(16'hFFFF, 1)));
            return int'(PosMagic);
         end
         1: begin
            put_le(PosInfo - 3, 4, InfoSize ^ pick_nonzero());
            return int'(PosInfo);
         end
         2: begin
            put_le(PosWidthF - 3, 4, pick_nonpositive());
            return int'(PosWidthF);
         end
         3: begin
            put_le(PosHeight - 3, 4, pick_nonpositive());
            return int'(PosHeight);
         end
         4: begin
            put_le(PosPlanes - 1, 2, PlanesOne ^ 16'($urandom_range(16'hFFFF, 1)));
            return int'(PosPlanes);
         end
         5: begin
            put_le(PosComp - 3, 4, pick_nonzero());
            return int'(PosComp);
         end
         6: begin
            put_le(PosHres - 3, 4, pick_nonpositive());
            return int'(PosHres);
         end
         default: begin
            put_le(PosVres - 3, 4, pick_nonpositive());
            return int'(PosVres);
         end
      endcase
   endfunction

   task automatic wait_for_results();
      req_tvalid <= 1'b0;
      while (hdr_verdicts.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic test_short_files();
      send_byte(8'h42, 1'b1);
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b1);
      send_byte(8'h42, 1'b0);
      send_byte(8'h58, 1'b0);
      send_byte(8'h42, 1'b0);
      send_byte(8'h4D, 1'b0);
      send_byte(8'h00, 1'b1);
   endtask

   task automatic test_extreme_headers();
      make_header();
      put_le(PosSize - 3, 4, '1);
      put_le(PosOffset - 3, 4, '0);
      put_le(PosWidthF - 3, 4, 32'h7FFF_FFFF);
      put_le(PosHeight - 3, 4, 32'd1);
      put_le(PosBpp - 1, 2, 16'hFFFF);
      put_le(PosHres - 3, 4, 32'd1);
      put_le(PosVres - 3, 4, 32'h7FFF_FFFF);
      put_le(PosColors - 3, 4, '0);
      send_stream(HeaderBytes, 0);
      make_header();
      put_le(PosSize - 3, 4, '0);
      put_le(PosOffset - 3, 4, '1);
      put_le(PosWidthF - 3, 4, 32'd1);
      put_le(PosHeight - 3, 4, 32'h7FFF_FFFF);
      put_le(PosBpp - 1, 2, 16'h0000);
      put_le(PosColors - 3, 4, '1);
      send_stream(HeaderBytes, 4);
   endtask

   task automatic test_random_files(input int byte_goal, input int file_goal);
      int byte_base;
      int file_base;
      int mode;
      int fail_pos;
      byte_base = bytes_sent;
      file_base = files_sent;
      while (bytes_sent - byte_base < byte_goal || files_sent - file_base < file_goal) begin
         mode = $urandom_range(99);
         make_header();
         if (mode < 40) begin
            send_stream(HeaderBytes, $urandom_range(2) == 0 ? 0 : $urandom_range(6, 1));
         end else if (mode < 70) begin
            fail_pos = break_field($urandom_range(7));
            send_stream($urandom_range(HeaderBytes, fail_pos + 1), $urandom_range(2));
         end else if (mode < 88) begin
            send_stream($urandom_range(PosLast, 1), 0);
         end else begin
            for (int i = 0; i < HeaderBytes; i++) hdr_img[i] = ByteWidth'($urandom);
            send_stream($urandom_range(8, 1), 0);
         end
      end
   endtask

   task automatic test_steady_stream();
      idling_on = 1'b0;
      test_random_files(300, 0);
      idling_on = 1'b1;
   endtask

   task automatic test_output_stall();
      rsp_hold = 80;
      for (int i = 0; i < 12; i++) begin
         hdr_img[0] = ByteWidth'($urandom);
         hdr_img[1] = ByteWidth'($urandom);
         send_stream(2, 0);
      end
   endtask

   task automatic test_drain_pause();
      wait_for_results();
      make_header();
      send_stream(HeaderBytes, 2);
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_short_files();
      test_extreme_headers();
      test_steady_stream();
      test_random_files(900, 20);
      test_output_stall();
      test_drain_pause();
      wait_for_results();
      if (fail_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (rsp_hold > 0) begin
         rsp_tready <= 1'b0;
         rsp_hold   <= rsp_hold - 1;
      end else begin
         rsp_tready <= !(idling_on && $urandom_range(99) < 14);
      end
   end

   function automatic void check_field(input string name, input logic [WordWidth-1:0] want,
                                       input logic [WordWidth-1:0] seen);
      if (want !== seen) begin
         $error("%s expected %0h got %0h", name, want, seen);
         fail_count++;
      end
   endfunction

   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (hdr_verdicts.size() == 0) begin
            $error("result transfer with no header result pending, status %0d", rsp_tuser);
            fail_count++;
         end else begin
            want = hdr_verdicts.pop_front();
            check_field("status", WordWidth'(want.status), WordWidth'(rsp_tuser));
            check_field("image_width", WordWidth'(want.image_width),
                        WordWidth'(rsp_tdata[30:0]));
            check_field("image_height", WordWidth'(want.image_height),
                        WordWidth'(rsp_tdata[61:31]));
            check_field("bits_per_pixel", WordWidth'(want.bits_per_pixel),
                        WordWidth'(rsp_tdata[77:62]));
            check_field("pixel_offset", want.pixel_offset, rsp_tdata[109:78]);
            check_field("file_size", want.file_size, rsp_tdata[141:110]);
            check_field("colors_used", want.colors_used, rsp_tdata[173:142]);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= WatchdogLimit) begin
         $display("FAIL");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

endmodule

`default_nettype wire
